FILE: rtl/core/aprc_pkg.sv
// Package for the aging page replacement core: sizes, operation codes,
// transaction payload structs and the cell control and search token types.
// No dependencies.
`default_nettype none

package aprc_pkg;

  // Sizing
  localparam int NUM_PAGES = 8;
  localparam int AGE_BITS  = 8;
  localparam int IDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CFG_W     = 4;
  localparam int VAGE_W    = (AGE_BITS > 8) ? AGE_BITS : 8;

  // Operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_ACCESS  = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_FIND    = 2'd2,
    FUNC_PRESENT = 2'd3
  } func_t;

  // Input transaction
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] page_index;
    logic       present_value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic       found;
    logic [2:0] victim_index;
    logic [7:0] victim_age;
  } out_item_t;

  // Per-cell update controls, decoded in the top level
  typedef struct packed {
    logic in_use;
    logic set_ref;
    logic tick;
    logic wr_pres;
    logic pres_val;
  } cell_ctl_t;

  // Minimum-search token passed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [AGE_BITS-1:0] best_age;
    logic [IDX_W-1:0]    best_idx;
  } srch_tok_t;

endpackage : aprc_pkg

`default_nettype wire

FILE: rtl/core/aprc_cell.sv
// One page cell: holds the page's age, reference bit and present bit, and
// forwards the minimum-search token to the next cell. Depends on aprc_pkg.
`default_nettype none

module aprc_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire [aprc_pkg::IDX_W-1:0] cell_idx,
  input  aprc_pkg::cell_ctl_t       ctl,
  input  aprc_pkg::srch_tok_t       tok_in,
  output aprc_pkg::srch_tok_t       tok_out
);
  import aprc_pkg::*;

  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic                ref_r, ref_nxt;
  logic                pres_r, pres_nxt;
  srch_tok_t           tok_r, tok_nxt;
  logic                better;

  // Page state update
  always_comb begin
    age_nxt  = age_r;
    ref_nxt  = ref_r;
    pres_nxt = pres_r;
    if (ctl.set_ref) begin
      ref_nxt = 1'b1;
    end
    if (ctl.tick) begin
      ref_nxt = 1'b0;
      if (ctl.in_use) begin
        age_nxt = {ref_r, age_r[AGE_BITS-1:1]};
      end
    end
    if (ctl.wr_pres) begin
      pres_nxt = ctl.pres_val;
    end
  end

  // Search step: strict less keeps the lower index on ties and
  // never picks an all-ones age
  assign better = tok_in.valid && ctl.in_use && pres_r && (age_r < tok_in.best_age);

  always_comb begin
    tok_nxt = tok_in;
    if (better) begin
      tok_nxt.hit      = 1'b1;
      tok_nxt.best_age = age_r;
      tok_nxt.best_idx = cell_idx;
    end
  end

  // Page state and search token registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r  <= '0;
      ref_r  <= 1'b0;
      pres_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      age_r  <= age_nxt;
      ref_r  <= ref_nxt;
      pres_r <= pres_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule : aprc_cell

`default_nettype wire

FILE: rtl/core/aging_page_replacement_core.sv
// Top level of the aging page replacement core: command decode, the row of
// page cells, control sequencer and result register. Depends on aprc_pkg, aprc_cell.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid, in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid, out_stall| out_data (out_item_t)
//   cfg_    | input     | cfg_valid, cfg_ready| cfg_data (pages_in_use, 4 bits)
//
// Access, tick and set-present results pass through the HOLD state to the
// output register; a find result first waits in SEARCH while the search token
// moves one cell per cycle along the row. One transaction is in flight at a
// time; in_stall is high until its result is loaded into the output register,
// so no new transaction is taken before that result is loaded.
// Reset is synchronous: all page state clears and pages_in_use returns to 8.
// cfg_ready is always high.
`default_nettype none

module aging_page_replacement_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  aprc_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output aprc_pkg::out_item_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [aprc_pkg::CFG_W-1:0]    cfg_data
);
  import aprc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  state_t                 state_r;
  logic [CFG_W-1:0]       pages_r;
  logic [CFG_W-1:0]       eff_cnt;
  logic                   in_acc;
  logic                   out_free;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  out_item_t              res_r;
  out_item_t              tail_res;
  logic [VAGE_W-1:0]      tail_age_ext;
  logic                   idx_ok;
  func_t                  func;
  cell_ctl_t              ctl   [NUM_PAGES];
  srch_tok_t              tok   [NUM_PAGES+1];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign func      = func_t'(in_data.func);

  // Effective page count, clamped to the number of cells
  assign eff_cnt = (pages_r > CFG_W'(NUM_PAGES)) ? CFG_W'(NUM_PAGES) : pages_r;
  assign idx_ok  = ({1'b0, in_data.page_index} < eff_cnt);

  // Per-cell decode
  for (genvar i = 0; i < NUM_PAGES; i++) begin : g_cell
    logic page_sel;
    assign page_sel        = (in_data.page_index == 3'(i));
    assign ctl[i].in_use   = (CFG_W'(i) < eff_cnt);
    assign ctl[i].set_ref  = in_acc && (func == FUNC_ACCESS) && page_sel && idx_ok;
    assign ctl[i].tick     = in_acc && (func == FUNC_TICK);
    assign ctl[i].wr_pres  = in_acc && (func == FUNC_PRESENT) && page_sel && idx_ok;
    assign ctl[i].pres_val = in_data.present_value;

    aprc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl[i]),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // Search launch token
  assign tok[0].valid    = in_acc && (func == FUNC_FIND);
  assign tok[0].hit      = 1'b0;
  assign tok[0].best_age = '1;
  assign tok[0].best_idx = '0;

  // Result from the tail of the row
  assign tail_age_ext          = VAGE_W'(tok[NUM_PAGES].best_age);
  assign tail_res.found        = tok[NUM_PAGES].hit;
  assign tail_res.victim_index = tok[NUM_PAGES].hit ? 3'(tok[NUM_PAGES].best_idx) : 3'd0;
  assign tail_res.victim_age   = tok[NUM_PAGES].hit ? tail_age_ext[7:0] : 8'd0;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pages_r     <= CFG_W'(NUM_PAGES);
    end else begin
      if (cfg_valid && cfg_ready) begin
        pages_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= (func == FUNC_FIND) ? ST_SEARCH : ST_HOLD;
          end
        end
        ST_SEARCH: begin
          if (tok[NUM_PAGES].valid) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= '0;
    end else if (state_r == ST_SEARCH && tok[NUM_PAGES].valid) begin
      res_r <= tail_res;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_data_r <= res_r;
    end
  end

endmodule : aging_page_replacement_core

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for aging_page_replacement_core: drives access, tick,
// find and set-present transactions and page count writes, predicts each result
// and checks it. Depends on aprc_pkg and the core RTL.

module tb_top;
  import aprc_pkg::*;

  localparam int SETTLE_CYCLES = NUM_PAGES + 4;  // longest op (find) plus margin
  localparam int HOLD_CYCLES   = 300;            // long receiver hold-off
  localparam int WATCHDOG_MAX  = 3000;           // cycles with no transaction at all
  localparam out_item_t NO_VICTIM = '0;

  // Directed stimulus row: op, and an optional hand-written expectation
  typedef struct packed {
    in_item_t  op;
    logic      pinned;
    out_item_t want;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // Predicted page state, own copy
  logic [CFG_W-1:0]    pages_cfg = 4'd8;
  logic [NUM_PAGES-1:0] ref_bits = '0;
  logic [NUM_PAGES-1:0] present_bits = '0;
  logic [AGE_BITS-1:0]  page_age [NUM_PAGES] = '{default: '0};

  out_item_t   pending_victims [$];
  logic        pin_set;
  out_item_t   pin_val;
  int unsigned ops_sent = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;

  // Directed part: expectations typed in where obvious, the rest predicted
  script_row_t intro_script [21] = '{
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b1, NO_VICTIM},          // nothing present
    '{'{FUNC_ACCESS,  3'd7, 1'b0}, 1'b1, NO_VICTIM},
    '{'{FUNC_TICK,    3'd0, 1'b0}, 1'b1, NO_VICTIM},
    '{'{FUNC_PRESENT, 3'd7, 1'b1}, 1'b1, NO_VICTIM},
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b1, '{1'b1, 3'd7, 8'h80}},
    '{'{FUNC_PRESENT, 3'd0, 1'b1}, 1'b1, NO_VICTIM},
    '{'{FUNC_PRESENT, 3'd1, 1'b1}, 1'b1, NO_VICTIM},
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b1, '{1'b1, 3'd0, 8'h00}},  // tie, lowest index
    '{'{FUNC_ACCESS,  3'd0, 1'b0}, 1'b0, NO_VICTIM},
    '{'{FUNC_ACCESS,  3'd5, 1'b1}, 1'b0, NO_VICTIM},
    '{'{FUNC_TICK,    3'd0, 1'b0}, 1'b0, NO_VICTIM},
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b0, NO_VICTIM},
    '{'{FUNC_PRESENT, 3'd1, 1'b0}, 1'b0, NO_VICTIM},          // evict, age kept
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b0, NO_VICTIM},
    '{'{FUNC_PRESENT, 3'd7, 1'b0}, 1'b0, NO_VICTIM},
    '{'{FUNC_FIND,    3'd7, 1'b1}, 1'b0, NO_VICTIM},
    '{'{FUNC_PRESENT, 3'd0, 1'b0}, 1'b0, NO_VICTIM},
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b0, NO_VICTIM},          // all evicted
    '{'{FUNC_TICK,    3'd7, 1'b1}, 1'b0, NO_VICTIM},
    '{'{FUNC_PRESENT, 3'd2, 1'b1}, 1'b0, NO_VICTIM},
    '{'{FUNC_FIND,    3'd0, 1'b0}, 1'b0, NO_VICTIM}
  };

  aging_page_replacement_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int tracked_pages();
    return (pages_cfg > NUM_PAGES) ? NUM_PAGES : int'(pages_cfg);
  endfunction

  // Apply one op to the predicted state and return the result it produces
  function automatic out_item_t advance_page_state(input in_item_t op);
    out_item_t res;
    int n;
    logic [AGE_BITS-1:0] best;
    res = NO_VICTIM;
    n = tracked_pages();
    case (func_t'(op.func))
      FUNC_ACCESS: begin
        if (op.page_index < n) ref_bits[op.page_index] = 1'b1;
      end
      FUNC_TICK: begin
        for (int i = 0; i < n; i++) page_age[i] = {ref_bits[i], page_age[i][AGE_BITS-1:1]};
        ref_bits = '0;
      end
      FUNC_FIND: begin
        // all-ones age never qualifies; strict compare keeps the lowest index
        best = '1;
        for (int i = 0; i < n; i++) begin
          if (present_bits[i] && page_age[i] < best) begin
            best = page_age[i];
            res.found = 1'b1;
            res.victim_index = i[2:0];
            res.victim_age = best[7:0];
          end
        end
      end
      default: begin
        if (op.page_index < n) present_bits[op.page_index] = op.present_value;
      end
    endcase
    return res;
  endfunction

  task automatic flag_result(input logic had_expect, input out_item_t want,
                             input out_item_t got);
    fail_count++;
    if (fail_count <= 10) begin
      if (had_expect)
        $display(
          "%0t: MISMATCH expected found=%0d idx=%0d age=%02h, got found=%0d idx=%0d age=%02h",
          $time, want.found, want.victim_index, want.victim_age,
          got.found, got.victim_index, got.victim_age);
      else
        $display("%0t: unexpected result found=%0d idx=%0d age=%02h",
                 $time, got.found, got.victim_index, got.victim_age);
    end
  endtask

  // Monitor: check results, predict accepted transactions, track config writes
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    out_item_t calc;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_victims.size() == 0) begin
          flag_result(1'b0, NO_VICTIM, got);
        end else begin
          want = pending_victims.pop_front();
          if (got.found !== want.found || got.victim_index !== want.victim_index ||
              got.victim_age !== want.victim_age)
            flag_result(1'b1, want, got);
        end
      end
      if (in_valid && !in_stall) begin
        calc = advance_page_state(in_data);
        pending_victims.push_back(pin_set ? pin_val : calc);
      end
      if (cfg_valid && cfg_ready) pages_cfg = cfg_data;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_victims.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one transaction; entered and left at a falling edge
  task automatic offer_op(input in_item_t op, input logic pinned, input out_item_t pinned_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    pin_set = pinned;
    pin_val = pinned_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_sent++;
    @(negedge clk);
  endtask

  task automatic send_op(input func_t f, input int p, input logic pv);
    in_item_t op;
    op.func = f;
    op.page_index = p[2:0];
    op.present_value = pv;
    offer_op(op, 1'b0, NO_VICTIM);
  endtask

  // Stop sending and wait until the core has returned everything
  task automatic settle_block();
    in_valid <= 1'b0;
    pin_set = 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_pages_cfg(input logic [CFG_W-1:0] val);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic built from short usage patterns plus some noise
  task automatic run_random(input int unsigned count);
    int unsigned goal;
    int kind;
    int n;
    int pg;
    logic [5:0] raw;
    goal = ops_sent + count;
    while (ops_sent < goal) begin
      kind = $urandom_range(99);
      pg = $urandom_range(7);
      if (kind < 15) begin
        // noise: any field combination
        repeat ($urandom_range(4, 1)) begin
          raw = 6'($urandom_range(63));
          offer_op(in_item_t'(raw), 1'b0, NO_VICTIM);
        end
      end else if (kind < 35) begin
        // load or evict, followed by a query half of the time
        send_op(FUNC_PRESENT, pg, ($urandom_range(9) < 7));
        if ($urandom_range(1)) send_op(FUNC_FIND, $urandom_range(7), 1'($urandom_range(1)));
      end else if (kind < 80) begin
        // usage window: accesses, tick, query
        repeat ($urandom_range(6, 1))
          send_op(FUNC_ACCESS, $urandom_range(7), 1'($urandom_range(1)));
        send_op(FUNC_TICK, $urandom_range(7), 1'($urandom_range(1)));
        send_op(FUNC_FIND, $urandom_range(7), 1'($urandom_range(1)));
      end else if (kind < 98) begin
        send_op(FUNC_PRESENT, pg, 1'b0);
        send_op(FUNC_FIND, $urandom_range(7), 1'($urandom_range(1)));
      end else begin
        // saturate every tracked page to all-ones age
        n = tracked_pages();
        repeat (AGE_BITS) begin
          for (int i = 0; i < n; i++) send_op(FUNC_ACCESS, i, 1'b0);
          send_op(FUNC_TICK, 0, 1'b0);
        end
        send_op(FUNC_FIND, 0, 1'b0);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    pin_set   = 1'b0;
    pin_val   = NO_VICTIM;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, reset page count
    foreach (intro_script[i])
      offer_op(intro_script[i].op, intro_script[i].pinned, intro_script[i].want);

    // No idling; count above the page limit; long receiver hold-off early on
    write_pages_cfg(4'd15);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_random(330);

    // Sender mostly idle; zero tracked pages, then three with a full drain midway
    write_pages_cfg(4'd0);
    send_idle_pct = 88;
    run_random(60);
    write_pages_cfg(4'd3);
    run_random(140);
    settle_block();
    run_random(140);

    // Receiver mostly stalled, single page
    write_pages_cfg(4'd1);
    send_idle_pct = 0;
    stall_pct = 88;
    run_random(330);

    // Light idling on both sides
    write_pages_cfg(4'd5);
    send_idle_pct = 6;
    stall_pct = 6;
    run_random(200);
    write_pages_cfg(4'd8);
    run_random(200);

    settle_block();
    if (fail_count == 0 && pending_victims.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/aprc_pkg.sv
rtl/core/aprc_cell.sv
rtl/core/aging_page_replacement_core.sv
dv/tb_top.sv
